// ===== rtl/multi_queue_task_dispatcher_core_macros.svh =====
// assertion macros used by the dispatcher datapath
`ifndef MULTI_QUEUE_TASK_DISPATCHER_CORE_MACROS_SVH
`define MULTI_QUEUE_TASK_DISPATCHER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define MQD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MQD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mqd_pkg.sv =====
// shared types and constants of the multi-queue task dispatcher
package mqd_pkg;

	localparam int NUM_QUEUES_DEF   = 8;
	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int TASK_ID_BITS_DEF = 16;

	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_GIVEN    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	localparam logic REG_QUEUE_COUNT    = 1'b0;
	localparam logic REG_QUEUE_CAPACITY = 1'b1;

	localparam logic [3:0] QCOUNT_RESET = 4'd8;
	localparam logic [4:0] QCAP_RESET   = 5'd16;
	localparam logic [7:0] PWAIT_MAX    = 8'd255;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_NORM,
		OP_STEP,
		OP_CLR_HP,
		OP_PUSH,
		OP_POP,
		OP_HEAD_UPD,
		OP_FULL,
		OP_EMPTY,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		logic is_submit;
		logic hp_mode;
		logic norm_ok;
		logic hit;
		logic last;
		logic more;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/mqd_ram.sv =====
// generic single-write, single-read ram with registered read data
module mqd_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 128
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/mqd_ctrl.sv =====
// dispatcher control state machine
module mqd_ctrl
	import mqd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_op_t   op
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_NORM,
		S_SCAN,
		S_PUSH,
		S_POP_RD,
		S_POP,
		S_HEAD_RD,
		S_HEAD_UPD,
		S_EMIT
	} state_t;

	state_t state_q, state_nxt;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_nxt = state_q;
		op        = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op        = OP_LOAD;
					state_nxt = S_NORM;
				end
			end
			S_NORM: begin
				if (stat.hp_mode) begin
					state_nxt = S_SCAN;
				end else begin
					op = OP_NORM;
					// pointer may first need folding below the queue count
					if (stat.norm_ok) begin
						state_nxt = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (stat.hit) begin
					state_nxt = stat.is_submit ? S_PUSH : S_POP_RD;
				end else if (stat.last) begin
					if (stat.is_submit) begin
						op        = OP_FULL;
						state_nxt = S_EMIT;
					end else if (stat.hp_mode) begin
						// no priority head found, fall back to round robin
						op        = OP_CLR_HP;
						state_nxt = S_NORM;
					end else begin
						op        = OP_EMPTY;
						state_nxt = S_EMIT;
					end
				end else begin
					op = OP_STEP;
				end
			end
			S_PUSH: begin
				op        = OP_PUSH;
				state_nxt = S_EMIT;
			end
			S_POP_RD: begin
				state_nxt = S_POP;
			end
			S_POP: begin
				op        = OP_POP;
				state_nxt = stat.more ? S_HEAD_RD : S_EMIT;
			end
			S_HEAD_RD: begin
				state_nxt = S_HEAD_UPD;
			end
			S_HEAD_UPD: begin
				op        = OP_HEAD_UPD;
				state_nxt = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					op        = OP_EMIT;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/mqd_datapath.sv =====
// dispatcher datapath: queue bookkeeping, pointers, task store and result registers
`include "multi_queue_task_dispatcher_core_macros.svh"

module mqd_datapath
	import mqd_pkg::*;
#(
	parameter int NUM_QUEUES   = NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_op_t      op,
	output dp_stat_t    stat,
	input  logic        func,
	input  logic [15:0] task_id,
	input  logic        high_priority,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] out_task_id,
	output logic        out_high_priority,
	output logic [2:0]  queue_index
);

	localparam int NQ = NUM_QUEUES;
	localparam int QD = QUEUE_DEPTH;
	localparam int TB = TASK_ID_BITS;
	localparam int QW = (NQ > 1) ? $clog2(NQ) : 1;
	localparam int NW = $clog2(NQ + 1);
	localparam int SW = (QD > 1) ? $clog2(QD) : 1;
	localparam int FW = $clog2(QD + 1);
	localparam int TW = FW + 1;
	localparam int AW = (NQ * QD > 1) ? $clog2(NQ * QD) : 1;
	localparam int EW = TB + 1;
	localparam int XW = (NW > 4) ? NW : 4;
	localparam int YW = (FW > 5) ? FW : 5;

	logic [3:0]    qc_q;
	logic [4:0]    cap_cfg_q;
	logic [NW-1:0] n_act;
	logic [FW-1:0] cap_act;

	logic [FW-1:0] fill_q [NQ];
	logic [SW-1:0] head_q [NQ];
	logic [NQ-1:0] hhp_q;
	logic [QW-1:0] pprod_q, pcons_q, qi_q;
	logic [NW-1:0] k_q;
	logic [7:0]    pwait_q;
	logic          func_q, hpm_q;

	logic [TB-1:0] id_q;
	logic          hp_q;
	logic [1:0]    res_status_q;
	logic [15:0]   res_id_q;
	logic          res_hp_q;
	logic [2:0]    res_qi_q;

	logic [FW-1:0] fill_sel;
	logic [SW-1:0] head_sel, head_dec, head_inc, tail_slot;
	logic [TW-1:0] tail_sum;
	logic          hhp_sel;
	logic [QW-1:0] ptr_sel, ptr_inc, ptr_sub, qi_inc;
	logic          norm_ok, hit;
	logic [AW-1:0] base, raddr, waddr;
	logic [EW-1:0] rdata, wdata;
	logic          we;

	// queues in use and capacity, held inside the supported range
	always_comb begin
		if (qc_q == 4'd0) begin
			n_act = NW'(1);
		end else if (XW'(qc_q) > XW'(NQ)) begin
			n_act = NW'(NQ);
		end else begin
			n_act = NW'(qc_q);
		end
		if (YW'(cap_cfg_q) > YW'(QD)) begin
			cap_act = FW'(QD);
		end else begin
			cap_act = FW'(cap_cfg_q);
		end
	end

	assign fill_sel = fill_q[qi_q];
	assign head_sel = head_q[qi_q];
	assign hhp_sel  = hhp_q[qi_q];

	assign ptr_sel = func_q ? pcons_q : pprod_q;
	assign norm_ok = (NW'(ptr_sel) < n_act);
	assign ptr_inc = ((NW'(ptr_sel) + NW'(1)) == n_act) ? '0 : ptr_sel + QW'(1);
	assign ptr_sub = QW'(NW'(ptr_sel) - n_act);
	assign qi_inc  = ((NW'(qi_q) + NW'(1)) == n_act) ? '0 : qi_q + QW'(1);

	always_comb begin
		if (!func_q) begin
			hit = (fill_sel < cap_act);
		end else if (hpm_q) begin
			hit = (fill_sel != '0) && hhp_sel;
		end else begin
			hit = (fill_sel != '0);
		end
	end

	assign head_dec  = (head_sel == '0) ? SW'(QD - 1) : head_sel - SW'(1);
	assign head_inc  = (head_sel == SW'(QD - 1)) ? '0 : head_sel + SW'(1);
	assign tail_sum  = TW'(head_sel) + TW'(fill_sel);
	assign tail_slot = (tail_sum >= TW'(QD)) ? SW'(tail_sum - TW'(QD)) : SW'(tail_sum);

	assign base  = AW'(qi_q) * AW'(QD);
	assign raddr = base + AW'(head_sel);
	assign waddr = base + AW'(hp_q ? head_dec : tail_slot);
	assign wdata = {hp_q, id_q};
	assign we    = (op == OP_PUSH);

	mqd_ram #(
		.WIDTH (EW),
		.DEPTH (NQ * QD)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		stat.is_submit = !func_q;
		stat.hp_mode   = hpm_q;
		stat.norm_ok   = norm_ok;
		stat.hit       = hit;
		stat.last      = ((k_q + NW'(1)) == n_act);
		stat.more      = (fill_sel > FW'(1));
		stat.out_free  = !out_valid || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qc_q      <= QCOUNT_RESET;
			cap_cfg_q <= QCAP_RESET;
			for (int i = 0; i < NQ; i++) begin
				fill_q[i] <= '0;
				head_q[i] <= '0;
			end
			hhp_q     <= '0;
			pprod_q   <= '0;
			pcons_q   <= '0;
			qi_q      <= '0;
			k_q       <= '0;
			pwait_q   <= '0;
			func_q    <= 1'b0;
			hpm_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_QUEUE_COUNT:    qc_q <= cfg_data[3:0];
					REG_QUEUE_CAPACITY: cap_cfg_q <= cfg_data;
					default: ;
				endcase
			end
			case (op)
				OP_LOAD: begin
					func_q <= func;
					hpm_q  <= func && (pwait_q != 8'd0);
					qi_q   <= '0;
					k_q    <= '0;
				end
				OP_NORM: begin
					if (norm_ok) begin
						qi_q <= ptr_sel;
						k_q  <= '0;
						if (func_q) begin
							pcons_q <= ptr_inc;
						end else begin
							pprod_q <= ptr_inc;
						end
					end else if (func_q) begin
						pcons_q <= ptr_sub;
					end else begin
						pprod_q <= ptr_sub;
					end
				end
				OP_STEP: begin
					qi_q <= qi_inc;
					k_q  <= k_q + NW'(1);
				end
				OP_CLR_HP: begin
					hpm_q <= 1'b0;
				end
				OP_PUSH: begin
					fill_q[qi_q] <= fill_sel + FW'(1);
					if (hp_q) begin
						head_q[qi_q] <= head_dec;
						hhp_q[qi_q]  <= 1'b1;
						if (pwait_q != PWAIT_MAX) begin
							pwait_q <= pwait_q + 8'd1;
						end
					end else if (fill_sel == '0) begin
						hhp_q[qi_q] <= 1'b0;
					end
				end
				OP_POP: begin
					fill_q[qi_q] <= fill_sel - FW'(1);
					head_q[qi_q] <= head_inc;
					if (rdata[TB] && (pwait_q != 8'd0)) begin
						pwait_q <= pwait_q - 8'd1;
					end
				end
				OP_HEAD_UPD: begin
					// new head entry read back after a pop
					hhp_q[qi_q] <= rdata[TB];
				end
				default: ;
			endcase
			if (op == OP_EMIT) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				id_q <= TB'(task_id);
				hp_q <= high_priority;
			end
			OP_FULL: begin
				res_status_q <= ST_FULL;
				res_id_q     <= '0;
				res_hp_q     <= 1'b0;
				res_qi_q     <= '0;
			end
			OP_EMPTY: begin
				res_status_q <= ST_EMPTY;
				res_id_q     <= '0;
				res_hp_q     <= 1'b0;
				res_qi_q     <= '0;
			end
			OP_PUSH: begin
				res_status_q <= ST_ACCEPTED;
				res_id_q     <= '0;
				res_hp_q     <= 1'b0;
				res_qi_q     <= 3'(qi_q);
			end
			OP_POP: begin
				res_status_q <= ST_GIVEN;
				res_id_q     <= 16'(rdata[TB-1:0]);
				res_hp_q     <= rdata[TB];
				res_qi_q     <= 3'(qi_q);
			end
			OP_EMIT: begin
				status            <= res_status_q;
				out_task_id       <= res_id_q;
				out_high_priority <= res_hp_q;
				queue_index       <= res_qi_q;
			end
			default: ;
		endcase
	end

	`MQD_ASSERT_IMPL(a_push_room, op == OP_PUSH, fill_sel < cap_act, "push into a full queue")
	`MQD_ASSERT_IMPL(a_pop_nonempty, op == OP_POP, fill_sel != '0, "pop from an empty queue")
	`MQD_ASSERT_NEXT(a_scan_start, (op == OP_NORM) && norm_ok, NW'(qi_q) < n_act, "scan start outside queues in use")

endmodule

// ===== rtl/multi_queue_task_dispatcher_core.sv =====
// multi-queue task dispatcher top level
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall  | func, task_id, high_priority
//   out     | output    | out_valid / out_stall | status, out_task_id, out_high_priority, queue_index
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// a submit or a take scans the queues in turn, up to the queue count of them;
// the scan visits one queue per cycle
// a pointer left above a lowered queue count is folded down one subtraction per cycle
// reset clears the queue bookkeeping and pointers; the task store is not cleared
// in_stall is high from transfer until the result is registered; one finished result
// waits in the output register while the next item is taken
module multi_queue_task_dispatcher_core
	import mqd_pkg::*;
#(
	parameter int NUM_QUEUES   = NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [15:0] task_id,
	input  logic        high_priority,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] out_task_id,
	output logic        out_high_priority,
	output logic [2:0]  queue_index,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);

	dp_op_t   op;
	dp_stat_t stat;

	mqd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.op       (op)
	);

	mqd_datapath #(
		.NUM_QUEUES   (NUM_QUEUES),
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.TASK_ID_BITS (TASK_ID_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.op                (op),
		.stat              (stat),
		.func              (func),
		.task_id           (task_id),
		.high_priority     (high_priority),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status            (status),
		.out_task_id       (out_task_id),
		.out_high_priority (out_high_priority),
		.queue_index       (queue_index)
	);

endmodule

// ===== verif/mqd_checker.sv =====
// result checker for the multi-queue task dispatcher: predicts each result and compares
`timescale 1ns / 1ps
module mqd_checker
	import mqd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        func,
	input  logic [15:0] task_id,
	input  logic        high_priority,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [15:0] out_task_id,
	input  logic        out_high_priority,
	input  logic [2:0]  queue_index,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	output int          fail_count,
	output int          pending_count
);
	typedef struct packed {
		logic [1:0]  st;
		logic [15:0] id;
		logic        hp;
		logic [2:0]  q;
	} disp_result_t;

	logic [16:0] slot_mem [NUM_QUEUES_DEF][QUEUE_DEPTH_DEF];
	logic [3:0]  head [NUM_QUEUES_DEF];
	logic [4:0]  fill [NUM_QUEUES_DEF];
	int unsigned prod_ptr, cons_ptr, hp_waiting;
	logic [3:0]  qcount;
	logic [4:0]  qcap;
	disp_result_t result_q [$];

	function automatic logic [16:0] pop_task(int unsigned q);
		logic [16:0] e;
		e = slot_mem[q][head[q]];
		head[q] = head[q] + 4'd1;
		fill[q] = fill[q] - 5'd1;
		if (e[16] && hp_waiting > 0)
			hp_waiting--;
		return e;
	endfunction

	function automatic disp_result_t dispatch(logic f, logic [15:0] id, logic hp);
		int unsigned n, cap, start, q;
		disp_result_t r;
		logic [16:0] e;
		n = (qcount == 0) ? 1 : (qcount > NUM_QUEUES_DEF ? NUM_QUEUES_DEF : qcount);
		cap = (qcap > QUEUE_DEPTH_DEF) ? QUEUE_DEPTH_DEF : qcap;
		r = '0;
		if (f == 1'b0) begin
			start = prod_ptr;
			prod_ptr = (prod_ptr + 1) % n;
			for (int k = 0; k < n; k++) begin
				q = (start + k) % n;
				if (fill[q] < cap) begin
					if (hp) begin
						head[q] = head[q] - 4'd1;
						slot_mem[q][head[q]] = {1'b1, id};
						if (hp_waiting < PWAIT_MAX)
							hp_waiting++;
					end else begin
						slot_mem[q][head[q] + fill[q][3:0]] = {1'b0, id};
					end
					fill[q] = fill[q] + 5'd1;
					r.st = ST_ACCEPTED;
					r.q = 3'(q);
					return r;
				end
			end
			r.st = ST_FULL;
			return r;
		end
		if (hp_waiting != 0) begin
			for (int k = 0; k < n; k++) begin
				if (fill[k] > 0 && slot_mem[k][head[k]][16]) begin
					e = pop_task(k);
					r.st = ST_GIVEN; r.id = e[15:0]; r.hp = e[16]; r.q = 3'(k);
					return r;
				end
			end
		end
		start = cons_ptr;
		cons_ptr = (cons_ptr + 1) % n;
		for (int k = 0; k < n; k++) begin
			q = (start + k) % n;
			if (fill[q] > 0) begin
				e = pop_task(q);
				r.st = ST_GIVEN; r.id = e[15:0]; r.hp = e[16]; r.q = 3'(q);
				return r;
			end
		end
		r.st = ST_EMPTY;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		disp_result_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES_DEF; i++) begin
				head[i] = '0;
				fill[i] = '0;
			end
			prod_ptr = 0;
			cons_ptr = 0;
			hp_waiting = 0;
			qcount = QCOUNT_RESET;
			qcap = QCAP_RESET;
			fail_count = 0;
			result_q.delete();
			pending_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_QUEUE_COUNT)
					qcount = cfg_data[3:0];
				else
					qcap = cfg_data;
			end
			if (in_valid && !in_stall)
				result_q.push_back(dispatch(func, task_id, high_priority));
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_count++;
				end else begin
					exp_r = result_q.pop_front();
					if (status !== exp_r.st) begin
						$error("status expected %0d actual %0d", exp_r.st, status);
						fail_count++;
					end
					if (out_task_id !== exp_r.id) begin
						$error("out_task_id expected %0h actual %0h", exp_r.id, out_task_id);
						fail_count++;
					end
					if (out_high_priority !== exp_r.hp) begin
						$error("out_high_priority expected %0d actual %0d",
							exp_r.hp, out_high_priority);
						fail_count++;
					end
					if (queue_index !== exp_r.q) begin
						$error("queue_index expected %0d actual %0d", exp_r.q, queue_index);
						fail_count++;
					end
				end
			end
			pending_count = result_q.size();
		end
	end
endmodule

// ===== verif/tb_multi_queue_task_dispatcher_core.sv =====
// testbench top for the multi-queue task dispatcher: stimulus and verdict
`timescale 1ns / 1ps
module tb_multi_queue_task_dispatcher_core;
	import mqd_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        func = 1'b0;
	logic [15:0] task_id = '0;
	logic        high_priority = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [15:0] out_task_id;
	logic        out_high_priority;
	logic [2:0]  queue_index;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [4:0]  cfg_data = '0;
	int          fail_count;
	int          pending_count;
	bit          sink_busy_mode = 1'b1;

	always #6 clk = ~clk;

	multi_queue_task_dispatcher_core u_dut (.*);
	mqd_checker u_chk (.*);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// output side back-pressure
	always @(posedge clk) begin
		if (sink_busy_mode && $urandom_range(0, 3) == 0)
			out_stall <= ($urandom_range(0, 9) == 0) ? 1'b1 : ~out_stall;
		else if (!sink_busy_mode)
			out_stall <= 1'b0;
	end

	task automatic send_task(logic f, logic [15:0] id, logic hp, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		repeat (g) @(posedge clk);
		in_valid <= 1'b1;
		func <= f;
		task_id <= id;
		high_priority <= hp;
		do @(posedge clk); while (in_stall);
		in_valid <= 1'b0;
		// the block stalls after a transfer, so this idle edge costs nothing
		@(posedge clk);
	endtask

	task automatic drain_and_write(logic idx, logic [4:0] val);
		while (pending_count != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [4:0] counts [6];
		logic [4:0] caps [6];
		counts = '{5'd8, 5'd1, 5'd0, 5'd15, 5'd3, 5'd8};
		caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd5};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, priority head insert, empty take
		send_task(1'b1, 16'h0000, 1'b0, 0);
		send_task(1'b0, 16'hffff, 1'b1, 0);
		send_task(1'b0, 16'h0000, 1'b0, 0);
		send_task(1'b0, 16'h1234, 1'b0, 0);
		send_task(1'b0, 16'hA5A5, 1'b1, 0);
		for (int i = 0; i < 6; i++) send_task(1'b1, 16'hffff, 1'b1, 0);
		drain_and_write(REG_QUEUE_CAPACITY, 5'd1);
		drain_and_write(REG_QUEUE_COUNT, 5'd2);
		for (int i = 0; i < 4; i++) send_task(1'b0, 16'(16'h5A00 + i), i[0], 0);
		for (int i = 0; i < 4; i++) send_task(1'b1, 16'h0, 1'b0, 0);
		drain_and_write(REG_QUEUE_CAPACITY, 5'd0);
		send_task(1'b0, 16'h7777, 1'b0, 0);
		for (int ph = 0; ph < 6; ph++) begin
			drain_and_write(REG_QUEUE_COUNT, counts[ph]);
			drain_and_write(REG_QUEUE_CAPACITY, caps[ph]);
			sink_busy_mode = (ph % 2 == 0);
			for (int i = 0; i < 115; i++) begin
				// bias toward submits in bursts so queues fill up, then drain
				if ((i / 30) % 2 == 0)
					send_task($urandom_range(0, 3) == 0, 16'($urandom),
						$urandom_range(0, 2) == 0, ph != 3);
				else
					send_task($urandom_range(0, 3) != 0, 16'($urandom),
						1'($urandom_range(0, 1)), ph != 3);
			end
		end
		while (pending_count != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
